>>> design/color_sensor_frequency_reader_core_defines.svh
// Assertion macros used by the color sensor reader controller
`ifndef COLOR_SENSOR_FREQUENCY_READER_CORE_DEFINES_SVH
`define COLOR_SENSOR_FREQUENCY_READER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CSFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csfr same-cycle check failed");

// Next-cycle implication, disabled during reset
`define CSFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csfr next-cycle check failed");

`endif

>>> design/csfr_pkg.sv
// Types, codes and constants of the color sensor frequency reader
package csfr_pkg;

  localparam int COUNT_WIDTH     = 16;
  localparam int VALUE_WIDTH     = 16;
  localparam int NUM_WIDTH       = COUNT_WIDTH + VALUE_WIDTH;
  localparam int STEP_WIDTH      = $clog2(NUM_WIDTH);
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEGRAL_TIME = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DARK_RED      = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DARK_GREEN    = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DARK_BLUE     = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SERIAL_NUMBER = 3'd4;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_RAW  = 2'd1;
  localparam logic [1:0] OP_RGB  = 2'd2;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_RAW   = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NOCAL = 2'd1;
  localparam logic [1:0] STATUS_UNDER = 2'd2;

  localparam logic KIND_SELECT  = 1'b0;
  localparam logic KIND_READING = 1'b1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX     = '1;
  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX     = '1;
  localparam logic [15:0]            DARK_UNCAL    = 16'hffff;
  localparam logic [31:0]            SERIAL_UNPROG = 32'hffff_ffff;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_RAW,
    MODE_RGB
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN,
    S_SEL
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       sensor_level;
  } in_item_t;

  typedef struct packed {
    logic                   kind;
    logic [1:0]             channel;
    logic [VALUE_WIDTH-1:0] value;
    logic [1:0]             status;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic fin_load;
    logic sel_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_finish;
    logic zero_finish;
    logic fin_two;
    logic out_free;
  } dp_status_t;

endpackage

>>> design/csfr_dp.sv
// Datapath: configuration, channel counters, shift-subtract divider, result register
module csfr_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [csfr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [csfr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  csfr_pkg::in_item_t                  in_data,
  input  csfr_pkg::ctrl_cmd_t                 cmd,
  output csfr_pkg::dp_status_t                status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output csfr_pkg::out_item_t                 out_data
);

  logic [15:0]                      integral_time;
  logic [15:0]                      dark_red;
  logic [15:0]                      dark_green;
  logic [15:0]                      dark_blue;
  logic [31:0]                      serial_number;

  csfr_pkg::mode_t                  mode;
  logic [1:0]                       channel;
  logic                             ref_taken;
  logic                             prev_level;
  logic [15:0]                      tick_count;
  logic [csfr_pkg::COUNT_WIDTH-1:0] edge_count;

  logic [15:0]                      rem;
  logic [csfr_pkg::NUM_WIDTH-1:0]   quo;

  logic                             is_start;
  logic                             is_tick;
  logic                             nocal;
  logic [15:0]                      tick_next;
  logic [csfr_pkg::COUNT_WIDTH-1:0] edge_next;
  logic                             finish;
  logic [csfr_pkg::NUM_WIDTH-1:0]   numer;
  logic [17:0]                      trial;
  logic                             start_load;
  csfr_pkg::out_item_t              start_item;

  logic [csfr_pkg::VALUE_WIDTH-1:0] reading;
  logic [15:0]                      dark;
  csfr_pkg::out_item_t              fin_item;
  logic                             fin_two;
  csfr_pkg::mode_t                  fin_mode;
  logic [1:0]                       fin_channel;

  // Classify the item at the input; next counts, divider numerator and start result
  always_comb begin
    is_start  = (in_data.opcode == csfr_pkg::OP_RAW || in_data.opcode == csfr_pkg::OP_RGB)
                && mode == csfr_pkg::MODE_IDLE;
    is_tick   = in_data.opcode == csfr_pkg::OP_TICK && mode != csfr_pkg::MODE_IDLE;
    nocal     = serial_number == csfr_pkg::SERIAL_UNPROG || dark_red == csfr_pkg::DARK_UNCAL;
    tick_next = tick_count + 16'd1;
    if (in_data.sensor_level != prev_level && edge_count != csfr_pkg::COUNT_MAX) begin
      edge_next = edge_count + csfr_pkg::COUNT_WIDTH'(1);
    end else begin
      edge_next = edge_count;
    end
    if (ref_taken) begin
      finish = is_tick && tick_next >= integral_time;
    end else begin
      finish = is_tick && integral_time == 16'd0;
    end
    // count * 65535 as (count << 16) - count
    numer = {edge_next, csfr_pkg::VALUE_WIDTH'(0)} - csfr_pkg::NUM_WIDTH'(edge_next);
    start_load = cmd.accept && is_start && in_data.opcode == csfr_pkg::OP_RGB;
    start_item.kind    = nocal ? csfr_pkg::KIND_READING : csfr_pkg::KIND_SELECT;
    start_item.channel = csfr_pkg::CH_RED;
    start_item.value   = '0;
    start_item.status  = nocal ? csfr_pkg::STATUS_NOCAL : csfr_pkg::STATUS_OK;
    start_item.last    = nocal;
  end

  assign trial = {1'b0, rem, quo[csfr_pkg::NUM_WIDTH-1]} - {2'b00, integral_time};

  // Channel end: saturate, correct for dark level, pick what follows
  always_comb begin
    if (quo[csfr_pkg::NUM_WIDTH-1:csfr_pkg::VALUE_WIDTH] != '0) begin
      reading = csfr_pkg::VALUE_MAX;
    end else begin
      reading = quo[csfr_pkg::VALUE_WIDTH-1:0];
    end
    case (channel)
      csfr_pkg::CH_RED:   dark = dark_red;
      csfr_pkg::CH_GREEN: dark = dark_green;
      default:            dark = dark_blue;
    endcase
    fin_item.kind    = csfr_pkg::KIND_READING;
    fin_item.channel = channel;
    fin_item.value   = reading - dark;
    fin_item.status  = csfr_pkg::STATUS_OK;
    fin_item.last    = 1'b1;
    fin_two          = 1'b0;
    fin_mode         = csfr_pkg::MODE_IDLE;
    fin_channel      = csfr_pkg::CH_RED;
    if (mode == csfr_pkg::MODE_RAW) begin
      fin_item.channel = csfr_pkg::CH_RAW;
      fin_item.value   = reading;
    end else if (reading < dark) begin
      fin_item.value  = '0;
      fin_item.status = csfr_pkg::STATUS_UNDER;
    end else if (channel != csfr_pkg::CH_BLUE) begin
      fin_item.last = 1'b0;
      fin_two       = 1'b1;
      fin_mode      = mode;
      fin_channel   = channel + 2'd1;
    end
  end

  assign status.div_finish  = finish && integral_time != 16'd0;
  assign status.zero_finish = finish && integral_time == 16'd0;
  assign status.fin_two     = fin_two;
  assign status.out_free    = !out_valid || out_ready;

  // Configuration and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_time <= 16'hffff;
      dark_red      <= '0;
      dark_green    <= '0;
      dark_blue     <= '0;
      serial_number <= '0;
      mode          <= csfr_pkg::MODE_IDLE;
      channel       <= csfr_pkg::CH_RED;
      ref_taken     <= 1'b0;
      prev_level    <= 1'b0;
      tick_count    <= '0;
      edge_count    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          csfr_pkg::REG_INTEGRAL_TIME: integral_time <= cfg_data[15:0];
          csfr_pkg::REG_DARK_RED:      dark_red      <= cfg_data[15:0];
          csfr_pkg::REG_DARK_GREEN:    dark_green    <= cfg_data[15:0];
          csfr_pkg::REG_DARK_BLUE:     dark_blue     <= cfg_data[15:0];
          csfr_pkg::REG_SERIAL_NUMBER: serial_number <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (cmd.accept && is_start) begin
        ref_taken  <= 1'b0;
        prev_level <= 1'b0;
        tick_count <= '0;
        edge_count <= '0;
        if (in_data.opcode == csfr_pkg::OP_RAW) begin
          mode    <= csfr_pkg::MODE_RAW;
          channel <= csfr_pkg::CH_RAW;
        end else if (!nocal) begin
          mode    <= csfr_pkg::MODE_RGB;
          channel <= csfr_pkg::CH_RED;
        end
      end else if (cmd.accept && is_tick) begin
        if (finish) begin
          ref_taken  <= 1'b0;
          prev_level <= 1'b0;
          tick_count <= '0;
          edge_count <= '0;
        end else if (!ref_taken) begin
          ref_taken  <= 1'b1;
          prev_level <= in_data.sensor_level;
          tick_count <= '0;
          edge_count <= '0;
        end else begin
          prev_level <= in_data.sensor_level;
          tick_count <= tick_next;
          edge_count <= edge_next;
        end
      end
      if (cmd.fin_load) begin
        mode    <= fin_mode;
        channel <= fin_channel;
      end
    end
  end

  // Divider: one quotient bit per step, quotient shifts in behind the numerator
  always_ff @(posedge clk) begin
    if (cmd.accept && is_tick && finish) begin
      rem <= '0;
      quo <= (integral_time == 16'd0) ? '0 : numer;
    end else if (cmd.div_step) begin
      if (!trial[17]) begin
        rem <= trial[15:0];
        quo <= {quo[csfr_pkg::NUM_WIDTH-2:0], 1'b1};
      end else begin
        rem <= {rem[14:0], quo[csfr_pkg::NUM_WIDTH-1]};
        quo <= {quo[csfr_pkg::NUM_WIDTH-2:0], 1'b0};
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (start_load || cmd.fin_load || cmd.sel_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_load) begin
      out_data <= start_item;
    end else if (cmd.fin_load) begin
      out_data <= fin_item;
    end else if (cmd.sel_load) begin
      out_data.kind    <= csfr_pkg::KIND_SELECT;
      out_data.channel <= channel;
      out_data.value   <= '0;
      out_data.status  <= csfr_pkg::STATUS_OK;
      out_data.last    <= 1'b0;
    end
  end

endmodule

>>> design/csfr_ctrl.sv
// Controller: item intake, divider sequencing and result handoff
`include "color_sensor_frequency_reader_core_defines.svh"

module csfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  csfr_pkg::dp_status_t status,
  output csfr_pkg::ctrl_cmd_t  cmd
);

  csfr_pkg::ctrl_state_t           state;
  csfr_pkg::ctrl_state_t           state_next;
  logic [csfr_pkg::STEP_WIDTH-1:0] cnt;
  logic [csfr_pkg::STEP_WIDTH-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csfr_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.fin_load = 1'b0;
    cmd.sel_load = 1'b0;
    unique case (state)
      csfr_pkg::S_IDLE: begin
        in_ready   = status.out_free;
        cmd.accept = in_valid && status.out_free;
        if (cmd.accept && status.div_finish) begin
          state_next = csfr_pkg::S_DIV;
          cnt_next   = csfr_pkg::STEP_WIDTH'(csfr_pkg::NUM_WIDTH - 1);
        end else if (cmd.accept && status.zero_finish) begin
          state_next = csfr_pkg::S_FIN;
        end
      end
      csfr_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - csfr_pkg::STEP_WIDTH'(1);
        if (cnt == '0) begin
          state_next = csfr_pkg::S_FIN;
        end
      end
      csfr_pkg::S_FIN: begin
        cmd.fin_load = 1'b1;
        state_next   = status.fin_two ? csfr_pkg::S_SEL : csfr_pkg::S_IDLE;
      end
      csfr_pkg::S_SEL: begin
        // hold the select until the result register frees up
        if (status.out_free) begin
          cmd.sel_load = 1'b1;
          state_next   = csfr_pkg::S_IDLE;
        end
      end
      default: state_next = csfr_pkg::S_IDLE;
    endcase
  end

  `CSFR_ASSERT_NEXT(a_div_enter, clk, rst, cmd.accept && status.div_finish, state == csfr_pkg::S_DIV)
  `CSFR_ASSERT_NEXT(a_div_leave, clk, rst, state == csfr_pkg::S_DIV && cnt == '0, state == csfr_pkg::S_FIN)
  `CSFR_ASSERT_NEXT(a_fin_exit, clk, rst, state == csfr_pkg::S_FIN, state == csfr_pkg::S_SEL || state == csfr_pkg::S_IDLE)
  `CSFR_ASSERT_IMPL(a_busy_no_take, clk, rst, state != csfr_pkg::S_IDLE, !in_ready && !cmd.accept)

endmodule

>>> design/color_sensor_frequency_reader_core.sv
// Top level of the color sensor frequency reader.
// A sample tick, a start command or an ignored item is handled in the idle
// state. A tick that ends a channel runs a shift-subtract divider for
// count*65535/integral_time, one quotient bit per cycle, 32 quotient bits at
// the 16-bit count width (COUNT_WIDTH + 16 in general), then applies the dark
// offset in RGB mode and loads the reading. With a zero integral time the
// channel ends on its reference tick, skips the divider and goes straight to
// loading its reading. Results leave through a single output register; when a
// select for the next channel follows a reading, it is loaded as soon as the
// reading is taken. A new item is taken whenever the controller is idle and the
// output register is empty or being emptied in that cycle.
module color_sensor_frequency_reader_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [csfr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [csfr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  csfr_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output csfr_pkg::out_item_t                  out_data
);

  csfr_pkg::ctrl_cmd_t  cmd;
  csfr_pkg::dp_status_t status;

  csfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  csfr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> verif/reading_checker.sv
// Predicts the reader's results from the observed channels and compares them
module reading_checker
  import csfr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  in_item_t                   in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  out_item_t                  out_data,
  output int                         errors,
  output int                         waiting,
  output int                         readings
);

  logic [15:0] window_len;
  logic [15:0] offset_red;
  logic [15:0] offset_green;
  logic [15:0] offset_blue;
  logic [31:0] serial_id;

  mode_t                  mode;
  logic [1:0]             chan;
  logic                   armed;
  logic                   last_level;
  logic [15:0]            tick_cnt;
  logic [COUNT_WIDTH-1:0] edge_cnt;

  out_item_t pending_results[$];
  int        fail_count = 0;
  int        seen_count = 0;

  assign errors   = fail_count;
  assign readings = seen_count;

  function automatic void queue_result(logic kind, logic [1:0] ch, logic [VALUE_WIDTH-1:0] val,
                                       logic [1:0] st, logic fin);
    out_item_t r;
    r.kind    = kind;
    r.channel = ch;
    r.value   = val;
    r.status  = st;
    r.last    = fin;
    pending_results.push_back(r);
  endfunction

  function automatic void restart_channel();
    armed      = 1'b0;
    last_level = 1'b0;
    tick_cnt   = '0;
    edge_cnt   = '0;
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] scale_count();
    longint unsigned num;
    if (window_len == 0) return '0;
    num = edge_cnt;
    num = num * VALUE_MAX;
    num = num / window_len;
    if (num > VALUE_MAX) num = VALUE_MAX;
    return num[VALUE_WIDTH-1:0];
  endfunction

  function automatic void end_channel();
    logic [VALUE_WIDTH-1:0] level_val;
    logic [15:0]            dark;
    logic [1:0]             ch;
    level_val = scale_count();
    ch = chan;
    restart_channel();
    if (mode == MODE_RAW) begin
      queue_result(KIND_READING, CH_RAW, level_val, STATUS_OK, 1'b1);
      mode = MODE_IDLE;
      chan = CH_RED;
      return;
    end
    case (ch)
      CH_RED:   dark = offset_red;
      CH_GREEN: dark = offset_green;
      default:  dark = offset_blue;
    endcase
    if (level_val < dark) begin
      queue_result(KIND_READING, ch, '0, STATUS_UNDER, 1'b1);
      mode = MODE_IDLE;
      chan = CH_RED;
    end else if (ch == CH_BLUE) begin
      queue_result(KIND_READING, ch, level_val - dark, STATUS_OK, 1'b1);
      mode = MODE_IDLE;
      chan = CH_RED;
    end else begin
      queue_result(KIND_READING, ch, level_val - dark, STATUS_OK, 1'b0);
      chan = ch + 2'd1;
      queue_result(KIND_SELECT, chan, '0, STATUS_OK, 1'b0);
    end
  endfunction

  function automatic void advance_reader(in_item_t item);
    if (item.opcode == OP_RAW || item.opcode == OP_RGB) begin
      // drop starts while a run is in progress
      if (mode != MODE_IDLE) return;
      restart_channel();
      if (item.opcode == OP_RAW) begin
        mode = MODE_RAW;
        chan = CH_RAW;
        return;
      end
      if (serial_id == SERIAL_UNPROG || offset_red == DARK_UNCAL) begin
        queue_result(KIND_READING, CH_RED, '0, STATUS_NOCAL, 1'b1);
        return;
      end
      mode = MODE_RGB;
      chan = CH_RED;
      queue_result(KIND_SELECT, CH_RED, '0, STATUS_OK, 1'b0);
      return;
    end
    if (item.opcode != OP_TICK || mode == MODE_IDLE) return;
    // first tick of a channel latches the reference level, and ends the channel if the window is zero
    if (!armed) begin
      armed      = 1'b1;
      last_level = item.sensor_level;
      tick_cnt   = '0;
      edge_cnt   = '0;
      if (window_len == 0) end_channel();
      return;
    end
    if (item.sensor_level != last_level) begin
      if (edge_cnt != COUNT_MAX) edge_cnt = edge_cnt + 1'b1;
      last_level = item.sensor_level;
    end
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt >= window_len) end_channel();
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("result field %s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      window_len   = 16'hffff;
      offset_red   = '0;
      offset_green = '0;
      offset_blue  = '0;
      serial_id    = '0;
      mode         = MODE_IDLE;
      chan         = CH_RED;
      restart_channel();
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INTEGRAL_TIME: window_len   = cfg_data[15:0];
          REG_DARK_RED:      offset_red   = cfg_data[15:0];
          REG_DARK_GREEN:    offset_green = cfg_data[15:0];
          REG_DARK_BLUE:     offset_blue  = cfg_data[15:0];
          REG_SERIAL_NUMBER: serial_id    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) advance_reader(in_data);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d channel %0d value %0d status %0d last %0d",
                 out_data.kind, out_data.channel, out_data.value, out_data.status,
                 out_data.last);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          seen_count++;
          check_field("kind", want.kind, out_data.kind);
          check_field("channel", want.channel, out_data.channel);
          check_field("value", want.value, out_data.value);
          check_field("status", want.status, out_data.status);
          check_field("last", want.last, out_data.last);
        end
      end
    end
    waiting <= pending_results.size();
  end

endmodule

>>> verif/color_sensor_frequency_reader_core_tb.sv
// Stimulus and verdict for the color sensor frequency reader core
module color_sensor_frequency_reader_core_tb;
  import csfr_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         SETTLE_WAIT  = 48;
  localparam int         RANDOM_ITEMS = 1350;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_we    = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  in_item_t                   in_data   = '0;
  logic                       out_ready = 1'b0;
  logic                       in_ready;
  logic                       out_valid;
  out_item_t                  out_data;

  int errors;
  int waiting;
  int readings;

  bit          calm = 1'b1;
  int          out_hold = 0;
  int          sent = 0;
  int          settings_used = 0;
  int          runs = 0;
  logic [15:0] cur_window = 16'hffff;
  logic [15:0] cur_dark_red = '0;
  logic [31:0] cur_serial = '0;

  color_sensor_frequency_reader_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  reading_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (errors),
    .waiting   (waiting),
    .readings  (readings)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  // mostly short pauses, a few long ones
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold  <= 0;
    end else if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold  <= out_hold - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      out_hold  <= pause_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // keep valid high across back-to-back items; lower it only for a gap
  task automatic send_item(input logic [1:0] op, input logic level);
    int gap;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= {op, level};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] window, input logic [15:0] dr,
                               input logic [15:0] dg, input logic [15:0] db,
                               input logic [31:0] sn);
    settle();
    write_reg(REG_INTEGRAL_TIME, {16'd0, window});
    write_reg(REG_DARK_RED, {16'd0, dr});
    write_reg(REG_DARK_GREEN, {16'd0, dg});
    write_reg(REG_DARK_BLUE, {16'd0, db});
    write_reg(REG_SERIAL_NUMBER, sn);
    cfg_we       <= 1'b0;
    cur_window   = window;
    cur_dark_red = dr;
    cur_serial   = sn;
    settings_used++;
  endtask

  function automatic logic [15:0] pick_window();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'd0;
    if (r < 50) return 16'($urandom_range(1, 4));
    if (r < 85) return 16'($urandom_range(5, 24));
    return 16'($urandom_range(25, 120));
  endfunction

  function automatic logic [15:0] pick_dark();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 16'd0;
    if (r < 70) return 16'($urandom_range(0, 65535));
    if (r < 90) return 16'($urandom_range(0, 3000));
    return DARK_UNCAL;
  endfunction

  function automatic logic [31:0] pick_serial();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom;
    if (r < 95) return SERIAL_UNPROG;
    return 32'hffff_fffe;
  endfunction

  // one start followed by enough ticks to finish the whole run
  task automatic measure_run(input logic [1:0] op, input bit noisy);
    int   nticks;
    int   toggle_pct;
    int   i;
    logic level;
    bit   refused;
    refused = (op == OP_RGB) && (cur_serial == SERIAL_UNPROG || cur_dark_red == DARK_UNCAL);
    nticks  = refused ? 2 : ((op == OP_RAW) ? 1 : 3) * (int'(cur_window) + 1);
    case ($urandom_range(0, 4))
      0:       toggle_pct = 0;
      1:       toggle_pct = 20;
      2:       toggle_pct = 50;
      3:       toggle_pct = 85;
      default: toggle_pct = 100;
    endcase
    level = $urandom_range(0, 1);
    if (noisy && $urandom_range(0, 1) == 0) send_item(OP_TICK, $urandom_range(0, 1));
    send_item(op, $urandom_range(0, 1));
    sent++;
    runs++;
    for (i = 0; i < nticks; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) begin
        // a start here lands while the first channel is still being counted
        if (!refused && i < int'(cur_window))
          send_item(($urandom_range(0, 1) != 0) ? OP_RAW : OP_RGB, $urandom_range(0, 1));
        else
          send_item(OP_UNUSED, $urandom_range(0, 1));
      end
      if ($urandom_range(0, 99) < toggle_pct) level = ~level;
      send_item(OP_TICK, level);
      sent++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // full scale raw reading, idle tick, unused opcode, start while busy
    load_settings(16'd1, 16'd0, 16'd0, 16'd0, 32'h0000_0001);
    send_item(OP_TICK, 1'b1);
    send_item(OP_UNUSED, 1'b1);
    send_item(OP_RAW, 1'b0);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b1);
    send_item(OP_RGB, 1'b0);
    send_item(OP_RAW, 1'b1);
    send_item(OP_TICK, 1'b1);
    send_item(OP_TICK, 1'b1);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b1);
    send_item(OP_TICK, 1'b1);
    send_item(OP_TICK, 1'b1);

    // zero window: channels end on the reference tick, blue falls under its offset
    load_settings(16'd0, 16'd0, 16'd0, DARK_UNCAL, 32'h0);
    send_item(OP_RAW, 1'b1);
    send_item(OP_TICK, 1'b1);
    send_item(OP_RGB, 1'b0);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b1);
    send_item(OP_TICK, 1'b0);

    // uncalibrated device, by serial and by red offset
    load_settings(16'd1, 16'd0, 16'd0, 16'd0, SERIAL_UNPROG);
    send_item(OP_RGB, 1'b0);
    load_settings(16'd1, DARK_UNCAL, 16'd0, 16'd0, 32'h0);
    send_item(OP_RGB, 1'b1);

    // green reading below its offset ends the run
    load_settings(16'd2, 16'd1, 16'd40000, 16'd0, 32'h8000_0000);
    send_item(OP_RGB, 1'b0);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b1);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      load_settings(pick_window(), pick_dark(), pick_dark(), pick_dark(), pick_serial());
      repeat ($urandom_range(1, 3))
        measure_run(($urandom_range(0, 2) == 0) ? OP_RAW : OP_RGB, $urandom_range(0, 2) == 0);
    end

    settle();
    $display("covered %0d measurement runs under %0d register settings", runs, settings_used);
    $display("%0d results compared, %0d random items driven", readings, sent);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
